// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the drawing engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Rasterizer package
// Command codes, the queued command word and the sequencer states.
// ----------------------------------------------------------------------------
package lrr_pkg;

   localparam int IN_BITS     = 11;
   localparam int COLOR_BITS  = 8;
   localparam int THICK_BITS  = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_LINE    = 2'd1,
      OP_OUTLINE = 2'd2,
      OP_FILL    = 2'd3
   } lrr_op_type;

   typedef struct packed {
      lrr_op_type                  op;
      logic signed [IN_BITS-1:0]   sx;
      logic signed [IN_BITS-1:0]   sy;
      logic signed [IN_BITS-1:0]   ex;
      logic signed [IN_BITS-1:0]   ey;
      logic [COLOR_BITS-1:0]       color;
      logic [THICK_BITS-1:0]       thick;
   } lrr_cmd_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIVS   = 7'b0000010,
      ST_DIVW   = 7'b0000100,
      ST_SETTLE = 7'b0001000,
      ST_MUL    = 7'b0010000,
      ST_PIX    = 7'b0100000,
      ST_RESP   = 7'b1000000
   } lrr_state_type;

endpackage

// ===== rtl/lrr_channels.sv =====
// ----------------------------------------------------------------------------
// Rasterizer channels
// Valid/ready channels for drawing commands and pixel results.
// ----------------------------------------------------------------------------
interface lrr_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic signed [10:0] start_x;
   logic signed [10:0] start_y;
   logic signed [10:0] end_x;
   logic signed [10:0] end_y;
   logic [7:0]        draw_color;
   logic [5:0]        thickness;

   modport source (output valid, opcode, start_x, start_y, end_x, end_y, draw_color,
                   thickness, input ready);
   modport sink (input valid, opcode, start_x, start_y, end_x, end_y, draw_color,
                 thickness, output ready);
endinterface

interface lrr_rsp_if #(parameter int COORD_BITS = 13);
   logic                         valid;
   logic                         ready;
   logic                         pixel_valid;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic [7:0]                   pixel_color;
   logic                         command_done;
   logic                         rejected;

   modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_color,
                   command_done, rejected, input ready);
   modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_color,
                 command_done, rejected, output ready);
endinterface

// ===== rtl/line_and_rectangle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Line and rectangle rasterizer
// Thick lines, rectangle outlines and filled rectangles as pixel writes.
// ----------------------------------------------------------------------------
// Every command word returns exactly one result word; a tick advances the
// running command by one pixel. A tick during a run goes through the
// multiply, sum and step states, and the step state skips each exhausted
// pass or segment one at a time. Starting a segment runs the serial slope
// divider, so each rectangle edge and each filled row pays for it once. The
// front queue holds two words, so the source keeps going while a result waits.
module line_and_rectangle_rasterizer #(
   parameter int COORD_BITS    = 13,
   parameter int FRACTION_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   lrr_req_if.sink   req_chan,
   lrr_rsp_if.source rsp_chan
);
   import lrr_pkg::*;

   logic        q_valid;
   logic        q_ready;
   lrr_cmd_type q_cmd;

   lrr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd)
   );

   lrr_back #(.C(COORD_BITS), .F(FRACTION_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/lrr_div.sv =====
// ----------------------------------------------------------------------------
// Slope divider
// Restoring divider giving num/den * 2^F truncated toward zero, |num| <= |den|.
// ----------------------------------------------------------------------------
module lrr_div #(
   parameter int C = 13,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [C:0]   num,
   input  logic signed [C:0]   den,
   output logic                done,
   output logic signed [F+1:0] quot
);
   localparam int CNT_BITS = $clog2(F + 1);

   logic [C+1:0]        rem_ff, rem_in;
   logic [C:0]          den_ff, den_in;
   logic [F:0]          quot_ff, quot_in;
   logic                neg_ff, neg_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic                ge;
   logic [C+1:0]        rem_sub;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      ge      = rem_ff >= {1'b0, den_ff};
      rem_sub = ge ? rem_ff - {1'b0, den_ff} : rem_ff;
      if (start) begin
         rem_in  = {1'b0, (num < 0) ? (C+1)'(-num) : (C+1)'(num)};
         den_in  = (den < 0) ? (C+1)'(-den) : (C+1)'(den);
         neg_in  = num[C] ^ den[C];
         quot_in = '0;
         cnt_in  = CNT_BITS'(F);
         run_in  = 1'b1;
      end else if (run_ff) begin
         quot_in = {quot_ff[F-1:0], ge};
         rem_in  = {rem_sub[C:0], 1'b0};
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});

endmodule

// ===== rtl/lrr_front.sv =====
// ----------------------------------------------------------------------------
// Command front end
// Accepts command words, decodes the opcode and holds them in a short queue.
// ----------------------------------------------------------------------------
module lrr_front (
   input  logic                clock,
   input  logic                reset,
   lrr_req_if.sink             req_chan,
   output logic                q_valid,
   input  logic                q_ready,
   output lrr_pkg::lrr_cmd_type q_cmd
);
   import lrr_pkg::*;

   lrr_cmd_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic                 push, pop;
   lrr_cmd_type          cmd;
   lrr_op_type           op;

   always_comb begin
      case (req_chan.opcode)
         OP_LINE:    op = OP_LINE;
         OP_OUTLINE: op = OP_OUTLINE;
         OP_FILL:    op = OP_FILL;
         default:    op = OP_TICK;
      endcase
      cmd.op    = op;
      cmd.sx    = req_chan.start_x;
      cmd.sy    = req_chan.start_y;
      cmd.ex    = req_chan.end_x;
      cmd.ey    = req_chan.end_y;
      cmd.color = req_chan.draw_color;
      cmd.thick = req_chan.thickness;
   end

   assign req_chan.ready = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign push    = req_chan.valid && req_chan.ready;
   assign q_valid = count_ff != '0;
   assign pop     = q_valid && q_ready;
   assign q_cmd   = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/lrr_back.sv =====
// ----------------------------------------------------------------------------
// Drawing engine
// Runs commands from the queue: segment setup, pass and run stepping, pixels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrr_back #(
   parameter int C = 13,
   parameter int F = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  lrr_pkg::lrr_cmd_type q_cmd,
   lrr_rsp_if.source            rsp_chan
);
   import lrr_pkg::*;

   localparam int WIDE = C + 12;
   localparam int PROD = F + C + 3;
   localparam int ACC  = F + C + 4;
   localparam int OFFB = THICK_BITS + 1;
   localparam logic signed [C-1:0] POS_ONE = 1;

   lrr_state_type          state_ff, state_in;
   logic                   busy_ff, busy_in;
   logic                   phase_ff, phase_in;
   lrr_op_type             mode_ff, mode_in;
   logic [1:0]             seg_ff, seg_in;
   logic signed [C-1:0]    x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic signed [C-1:0]    fill_ff, fill_in;
   logic signed [C-1:0]    sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [F+1:0]    slope_ff, slope_in;
   logic signed [OFFB-1:0] offset_ff, offset_in;
   logic [THICK_BITS-1:0]  passes_ff, passes_in;
   logic signed [C-1:0]    pos_ff, pos_in;
   logic [COLOR_BITS-1:0]  color_ff, color_in;
   logic signed [PROD-1:0] prod_ff, prod_in;
   logic                   rv_ff, rv_in, rdone_ff, rdone_in, rrej_ff, rrej_in;
   logic [C-1:0]           rx_ff, rx_in, ry_ff, ry_in;
   logic [COLOR_BITS-1:0]  rcol_ff, rcol_in;

   // Combinational segment geometry.
   logic signed [C:0]      dx, dy;
   logic [C:0]             adx, ady;
   logic                   gentle;
   logic signed [C-1:0]    ra, rb, lo, hi;
   // Load request.
   logic                   ld;
   logic signed [C-1:0]    ld_sx, ld_sy, ld_ex, ld_ey;
   logic [THICK_BITS-1:0]  ld_p;
   // Command decode.
   logic signed [WIDE-1:0] w_sx, w_sy, w_ex, w_ey;
   logic signed [C-1:0]    c_sx, c_sy, c_ex, c_ey, c_x1, c_y1;
   // Pixel math.
   logic signed [C:0]      mul_diff;
   logic signed [C+1:0]    base_sum;
   logic signed [ACC-1:0]  acc;
   logic [C+3:0]           qv;
   logic signed [C-1:0]    nf;
   // Divider.
   logic                   div_start, div_done;
   logic signed [C:0]      div_num, div_den;
   logic signed [F+1:0]    div_quot;

   lrr_div #(.C(C), .F(F)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      dx     = (C+1)'(ex_ff) - (C+1)'(sx_ff);
      dy     = (C+1)'(ey_ff) - (C+1)'(sy_ff);
      adx    = (dx < 0) ? (C+1)'(-dx) : (C+1)'(dx);
      ady    = (dy < 0) ? (C+1)'(-dy) : (C+1)'(dy);
      gentle = ady <= adx;
      ra     = gentle ? sx_ff : sy_ff;
      rb     = gentle ? ex_ff : ey_ff;
      lo     = (ra < rb) ? ra : rb;
      hi     = (ra < rb) ? rb : ra;
      div_num = gentle ? dy : dx;
      div_den = gentle ? dx : dy;

      w_sx = WIDE'(q_cmd.sx);
      w_sy = WIDE'(q_cmd.sy);
      w_ex = WIDE'(q_cmd.ex);
      w_ey = WIDE'(q_cmd.ey);
      c_sx = C'(w_sx);
      c_sy = C'(w_sy);
      c_ex = C'(w_ex);
      c_ey = C'(w_ey);
      c_x1 = C'(w_sx + w_ex);
      c_y1 = C'(w_sy + w_ey);

      mul_diff = gentle ? (C+1)'(pos_ff) - (C+1)'(sx_ff) : (C+1)'(pos_ff) - (C+1)'(sy_ff);
      base_sum = (C+2)'(gentle ? sy_ff : sx_ff) + (C+2)'(offset_ff);
      acc      = ACC'(prod_ff) + (ACC'(base_sum) <<< F);
      // Floor shift, then step up for negative sums with a fraction.
      qv       = (C+4)'(acc >>> F) + (C+4)'(acc[ACC-1] && (acc[F-1:0] != '0));
      nf       = fill_ff + POS_ONE;
   end

   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      seg_in    = seg_ff;
      x0_in     = x0_ff;
      y0_in     = y0_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      fill_in   = fill_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      ex_in     = ex_ff;
      ey_in     = ey_ff;
      slope_in  = slope_ff;
      offset_in = offset_ff;
      passes_in = passes_ff;
      pos_in    = pos_ff;
      color_in  = color_ff;
      prod_in   = prod_ff;
      rv_in     = rv_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rcol_in   = rcol_ff;
      rdone_in  = rdone_ff;
      rrej_in   = rrej_ff;
      ld        = 1'b0;
      ld_sx     = x0_ff;
      ld_sy     = y0_ff;
      ld_ex     = x1_ff;
      ld_ey     = y0_ff;
      ld_p      = THICK_BITS'(1);
      div_start = 1'b0;
      q_ready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               rv_in    = 1'b0;
               rx_in    = '0;
               ry_in    = '0;
               rcol_in  = '0;
               rdone_in = 1'b0;
               rrej_in  = 1'b0;
               if (q_cmd.op == OP_TICK) begin
                  state_in = busy_ff ? ST_MUL : ST_RESP;
               end else if (busy_ff) begin
                  rrej_in  = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  mode_in  = q_cmd.op;
                  color_in = q_cmd.color;
                  phase_in = 1'b0;
                  if (q_cmd.op == OP_LINE) begin
                     ld    = 1'b1;
                     ld_sx = c_sx;
                     ld_sy = c_sy;
                     ld_ex = c_ex;
                     ld_ey = c_ey;
                     ld_p  = q_cmd.thick;
                     state_in = ST_DIVS;
                  end else begin
                     x0_in   = c_sx;
                     y0_in   = c_sy;
                     x1_in   = c_x1;
                     y1_in   = c_y1;
                     seg_in  = '0;
                     fill_in = c_sy;
                     if (q_cmd.op == OP_OUTLINE || c_sy < c_y1) begin
                        ld    = 1'b1;
                        ld_sx = c_sx;
                        ld_sy = c_sy;
                        ld_ex = c_x1;
                        ld_ey = c_sy;
                        state_in = ST_DIVS;
                     end else begin
                        passes_in = '0;
                        state_in  = ST_SETTLE;
                     end
                  end
               end
            end
         end
         ST_DIVS: begin
            pos_in = lo;
            if (dx == 0 && dy == 0) begin
               slope_in = '0;
               state_in = ST_SETTLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (div_done) begin
               slope_in = div_quot;
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            // One step per cycle: next pixel, next pass, next segment, or stop.
            if (passes_ff != '0 && pos_ff < hi) begin
               busy_in  = 1'b1;
               state_in = phase_ff ? ST_RESP : ST_MUL;
            end else if (passes_ff != '0) begin
               passes_in = passes_ff - 1'b1;
               offset_in = offset_ff - OFFB'(1);
               pos_in    = lo;
            end else begin
               busy_in  = 1'b0;
               rdone_in = 1'b1;
               state_in = ST_RESP;
               case (mode_ff)
                  OP_OUTLINE: begin
                     if (seg_ff != 2'd3) begin
                        seg_in   = seg_ff + 2'd1;
                        busy_in  = busy_ff;
                        rdone_in = rdone_ff;
                        state_in = ST_DIVS;
                        ld       = 1'b1;
                        case (seg_ff)
                           2'd0: begin
                              ld_sx = x0_ff;
                              ld_sy = y0_ff;
                              ld_ex = x0_ff;
                              ld_ey = y1_ff;
                           end
                           2'd1: begin
                              ld_sx = x1_ff;
                              ld_sy = y1_ff;
                              ld_ex = x1_ff;
                              ld_ey = y0_ff;
                           end
                           default: begin
                              ld_sx = x1_ff;
                              ld_sy = y1_ff;
                              ld_ex = x0_ff;
                              ld_ey = y1_ff;
                           end
                        endcase
                     end
                  end
                  OP_FILL: begin
                     if (fill_ff < y1_ff) begin
                        fill_in = nf;
                        if (nf < y1_ff) begin
                           busy_in  = busy_ff;
                           rdone_in = rdone_ff;
                           state_in = ST_DIVS;
                           ld       = 1'b1;
                           ld_sx    = x0_ff;
                           ld_sy    = nf;
                           ld_ex    = x1_ff;
                           ld_ey    = nf;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = slope_ff * mul_diff;
            state_in = ST_PIX;
         end
         ST_PIX: begin
            rv_in   = 1'b1;
            rcol_in = color_ff;
            if (gentle) begin
               rx_in = C'(pos_ff);
               // Right-to-left shallow lines sit one row higher.
               ry_in = (sx_ff >= ex_ff) ? C'(qv - 1'b1) : C'(qv);
            end else begin
               rx_in = C'(qv);
               ry_in = C'(pos_ff);
            end
            pos_in   = pos_ff + POS_ONE;
            phase_in = 1'b1;
            state_in = ST_SETTLE;
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ld) begin
         sx_in     = ld_sx;
         sy_in     = ld_sy;
         ex_in     = ld_ex;
         ey_in     = ld_ey;
         passes_in = ld_p;
         offset_in = OFFB'(ld_p >> 1);
      end
   end

   always_ff @(posedge clock) begin
      seg_ff    <= seg_in;
      x0_ff     <= x0_in;
      y0_ff     <= y0_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      fill_ff   <= fill_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      slope_ff  <= slope_in;
      offset_ff <= offset_in;
      pos_ff    <= pos_in;
      color_ff  <= color_in;
      prod_ff   <= prod_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      rcol_ff   <= rcol_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         phase_ff  <= 1'b0;
         mode_ff   <= OP_TICK;
         passes_ff <= '0;
         rv_ff     <= 1'b0;
         rdone_ff  <= 1'b0;
         rrej_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         phase_ff  <= phase_in;
         mode_ff   <= mode_in;
         passes_ff <= passes_in;
         rv_ff     <= rv_in;
         rdone_ff  <= rdone_in;
         rrej_ff   <= rrej_in;
      end
   end

   assign rsp_chan.valid        = state_ff == ST_RESP;
   assign rsp_chan.pixel_valid  = rv_ff;
   assign rsp_chan.pixel_x      = rx_ff;
   assign rsp_chan.pixel_y      = ry_ff;
   assign rsp_chan.pixel_color  = rcol_ff;
   assign rsp_chan.command_done = rdone_ff;
   assign rsp_chan.rejected     = rrej_ff;

   `ASSERT_IMP(a_div_den, clock, reset, div_start, div_den != 0, "divider started with zero")
   `ASSERT_IMP(a_rej_pix, clock, reset, rsp_chan.valid && rsp_chan.rejected,
      rsp_chan.pixel_valid, "rejected word without a pixel")
   `ASSERT_IMP(a_color, clock, reset, rsp_chan.valid && rsp_chan.pixel_valid,
      rsp_chan.pixel_color == color_ff, "pixel color differs from command color")
   `ASSERT_NXT(a_idle_tick, clock, reset,
      state_ff == ST_IDLE && q_valid && q_cmd.op == OP_TICK && !busy_ff,
      state_ff == ST_RESP, "idle tick did not answer at once")

endmodule
